// ----- sv/phr_pkg.sv -----
// phr_pkg: widths, constants and shared types of the palette hue replacer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package phr_pkg;

  localparam int CHAN_BITS = 8;
  localparam int IDX_BITS  = 8;
  localparam int HUE_BITS  = 8;
  localparam int FRAC_BITS = 16;
  localparam int RATIO_BITS = FRAC_BITS + 1;

  // Hue in 1/17 degree units: code * 24, full circle 6120.
  localparam int H_BITS    = 13;
  localparam int HUE_SCALE = 24;

  localparam logic [H_BITS-1:0] H_60  = H_BITS'(1020);
  localparam logic [H_BITS-1:0] H_120 = H_BITS'(2040);
  localparam logic [H_BITS-1:0] H_180 = H_BITS'(3060);
  localparam logic [H_BITS-1:0] H_240 = H_BITS'(4080);
  localparam logic [H_BITS-1:0] H_300 = H_BITS'(5100);
  localparam logic [H_BITS-1:0] H_360 = H_BITS'(6120);

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

  // Divider runs one quotient bit per cycle.
  localparam int DIV_STEPS = RATIO_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HUE_CODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_START = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_END   = 2'd2;

  typedef enum logic [2:0] {
    SEC_R_MAX_G_UP   = 3'd0,  // r max, b min, g third
    SEC_G_MAX_R_DOWN = 3'd1,  // g max, b min, r third
    SEC_G_MAX_B_UP   = 3'd2,  // g max, r min, b third
    SEC_B_MAX_G_DOWN = 3'd3,  // b max, r min, g third
    SEC_B_MAX_R_UP   = 3'd4,  // b max, g min, r third
    SEC_R_MAX_B_DOWN = 3'd5   // r max, g min, b third
  } sector_t;

  typedef struct packed {
    sector_t               sector;
    logic [RATIO_BITS-1:0] ratio;
  } hue_cfg_t;

endpackage

// ----- sv/palette_hue_replace.sv -----
// palette_hue_replace: recolors palette entries inside an index range to a
// configured hue, keeping each entry's largest and smallest channel.
// Items pass an input and a result register; 1 item per cycle while busy is low.
// A hue_code write holds busy high while the restoring divider
// forms the sector ratio one quotient bit per cycle; range writes cost nothing.
// Synchronous active-low reset: hue 0 (sector 0, ratio 0), range 0..255, empty
// pipeline; the receiver cannot stall, so out_valid is a one-cycle strobe.
`timescale 1ns / 1ps

module palette_hue_replace (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [phr_pkg::IDX_BITS-1:0]        in_entry_index,
  input  logic [phr_pkg::CHAN_BITS-1:0]       in_red_in,
  input  logic [phr_pkg::CHAN_BITS-1:0]       in_green_in,
  input  logic [phr_pkg::CHAN_BITS-1:0]       in_blue_in,
  output logic                                out_valid,
  output logic [phr_pkg::IDX_BITS-1:0]        out_index_out,
  output logic [phr_pkg::CHAN_BITS-1:0]       out_red_out,
  output logic [phr_pkg::CHAN_BITS-1:0]       out_green_out,
  output logic [phr_pkg::CHAN_BITS-1:0]       out_blue_out,
  input  logic                                cfg_we,
  input  logic [phr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [phr_pkg::HUE_BITS-1:0]        cfg_wdata
);

  logic [phr_pkg::IDX_BITS-1:0] range_start_r;
  logic [phr_pkg::IDX_BITS-1:0] range_end_r;
  logic                         hue_load;
  logic                         div_busy;
  logic                         accept;
  phr_pkg::hue_cfg_t            hue_cfg;

  assign hue_load = cfg_we && (cfg_index == phr_pkg::REG_HUE_CODE);
  assign accept   = start && !div_busy;
  assign busy     = div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= '0;
      range_end_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        phr_pkg::REG_RANGE_START: range_start_r <= phr_pkg::IDX_BITS'(cfg_wdata);
        phr_pkg::REG_RANGE_END:   range_end_r   <= phr_pkg::IDX_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  phr_ratio_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (hue_load),
    .code    (cfg_wdata),
    .hue_cfg (hue_cfg),
    .busy    (div_busy)
  );

  phr_recolor u_recolor (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .idx_in      (in_entry_index),
    .red_in      (in_red_in),
    .green_in    (in_green_in),
    .blue_in     (in_blue_in),
    .hue_cfg     (hue_cfg),
    .range_start (range_start_r),
    .range_end   (range_end_r),
    .out_valid   (out_valid),
    .idx_out     (out_index_out),
    .red_out     (out_red_out),
    .green_out   (out_green_out),
    .blue_out    (out_blue_out)
  );

endmodule

// ----- sv/phr_ratio_div.sv -----
// phr_ratio_div: decodes a written hue code into its sector and computes the
// sector ratio with a restoring divider, one quotient bit per cycle.
// Depends on phr_pkg.
`timescale 1ns / 1ps

module phr_ratio_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [phr_pkg::HUE_BITS-1:0]    code,
  output phr_pkg::hue_cfg_t               hue_cfg,
  output logic                            busy
);

  localparam int REM_BITS = phr_pkg::H_BITS + 1;

  logic [phr_pkg::H_BITS-1:0]     h;
  phr_pkg::sector_t               sec;
  logic [phr_pkg::H_BITS-1:0]     num;
  logic [phr_pkg::H_BITS-1:0]     den;

  phr_pkg::sector_t               sector_r;
  logic [phr_pkg::RATIO_BITS-1:0] ratio_r, ratio_nxt;
  logic [phr_pkg::RATIO_BITS-1:0] q_r, q_nxt;
  logic [REM_BITS-1:0]            rem_r, rem_nxt;
  logic [phr_pkg::H_BITS-1:0]     den_r;
  logic [phr_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;

  logic                           ge;
  logic [REM_BITS-1:0]            diff;

  always_comb begin
    h = phr_pkg::H_BITS'(code) * phr_pkg::H_BITS'(phr_pkg::HUE_SCALE);
    if (h < phr_pkg::H_60) begin
      sec = phr_pkg::SEC_R_MAX_G_UP;
      num = h;
      den = phr_pkg::H_120 - h;
    end else if (h <= phr_pkg::H_120) begin
      sec = phr_pkg::SEC_G_MAX_R_DOWN;
      num = phr_pkg::H_120 - h;
      den = h;
    end else if (h < phr_pkg::H_180) begin
      sec = phr_pkg::SEC_G_MAX_B_UP;
      num = h - phr_pkg::H_120;
      den = phr_pkg::H_240 - h;
    end else if (h <= phr_pkg::H_240) begin
      sec = phr_pkg::SEC_B_MAX_G_DOWN;
      num = phr_pkg::H_240 - h;
      den = h - phr_pkg::H_120;
    end else if (h < phr_pkg::H_300) begin
      sec = phr_pkg::SEC_B_MAX_R_UP;
      num = h - phr_pkg::H_240;
      den = phr_pkg::H_360 - h;
    end else begin
      sec = phr_pkg::SEC_R_MAX_B_DOWN;
      num = phr_pkg::H_360 - h;
      den = h - phr_pkg::H_240;
    end
  end

  // remainder stays below twice the divisor, so the shift never overflows
  always_comb begin
    ge        = rem_r >= {1'b0, den_r};
    diff      = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt   = {diff[REM_BITS-2:0], 1'b0};
    q_nxt     = {q_r[phr_pkg::RATIO_BITS-2:0], ge};
    cnt_nxt   = cnt_r - phr_pkg::CNT_BITS'(1);
    busy_nxt  = (cnt_r != phr_pkg::CNT_BITS'(1));
    if (den_r == '0) begin
      ratio_nxt = '0;
    end else if (q_nxt > phr_pkg::RATIO_ONE) begin
      ratio_nxt = phr_pkg::RATIO_ONE;
    end else begin
      ratio_nxt = q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_r <= phr_pkg::SEC_R_MAX_G_UP;
      ratio_r  <= '0;
      busy_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (load) begin
      sector_r <= sec;
      busy_r   <= 1'b1;
      cnt_r    <= phr_pkg::CNT_BITS'(phr_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      if (!busy_nxt) begin
        ratio_r <= ratio_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= REM_BITS'(num);
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign hue_cfg.sector = sector_r;
  assign hue_cfg.ratio  = ratio_r;
  assign busy           = busy_r;

  a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_r <= phr_pkg::RATIO_ONE)
    else $error("sector ratio above one");
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && cnt_r == phr_pkg::CNT_BITS'(phr_pkg::DIV_STEPS))
    else $error("divider did not start");
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !load && cnt_r == phr_pkg::CNT_BITS'(1) |=> !busy_r)
    else $error("divider overran its step count");
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with zero count");

endmodule

// ----- sv/phr_recolor.sv -----
// phr_recolor: input register, recolor datapath and result register.
// One item per cycle, from accept through both registers to the result. Depends on phr_pkg.
`timescale 1ns / 1ps

module phr_recolor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [phr_pkg::IDX_BITS-1:0]    idx_in,
  input  logic [phr_pkg::CHAN_BITS-1:0]   red_in,
  input  logic [phr_pkg::CHAN_BITS-1:0]   green_in,
  input  logic [phr_pkg::CHAN_BITS-1:0]   blue_in,
  input  phr_pkg::hue_cfg_t               hue_cfg,
  input  logic [phr_pkg::IDX_BITS-1:0]    range_start,
  input  logic [phr_pkg::IDX_BITS-1:0]    range_end,
  output logic                            out_valid,
  output logic [phr_pkg::IDX_BITS-1:0]    idx_out,
  output logic [phr_pkg::CHAN_BITS-1:0]   red_out,
  output logic [phr_pkg::CHAN_BITS-1:0]   green_out,
  output logic [phr_pkg::CHAN_BITS-1:0]   blue_out
);

  localparam int CB   = phr_pkg::CHAN_BITS;
  localparam int PROD = CB + phr_pkg::RATIO_BITS;

  logic          v1_r;
  logic [phr_pkg::IDX_BITS-1:0] idx1_r;
  logic [CB-1:0] r1_r, g1_r, b1_r;

  logic          vo_r;
  logic [phr_pkg::IDX_BITS-1:0] idxo_r;
  logic [CB-1:0] ro_r, go_r, bo_r;
  logic [CB-1:0] r_nxt, g_nxt, b_nxt;

  logic          in_range;
  logic [CB-1:0] mx, mn, third;
  logic [PROD-1:0] prod;
  logic [CB:0]   sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= accept;
      vo_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx1_r <= idx_in;
      r1_r   <= red_in;
      g1_r   <= green_in;
      b1_r   <= blue_in;
    end
    if (v1_r) begin
      idxo_r <= idx1_r;
      ro_r   <= r_nxt;
      go_r   <= g_nxt;
      bo_r   <= b_nxt;
    end
  end

  always_comb begin
    in_range = (idx1_r >= range_start) && (idx1_r <= range_end);
    mx = r1_r;
    if (g1_r > mx) mx = g1_r;
    if (b1_r > mx) mx = b1_r;
    mn = r1_r;
    if (g1_r < mn) mn = g1_r;
    if (b1_r < mn) mn = b1_r;
    prod  = PROD'(mx - mn) * PROD'(hue_cfg.ratio);
    sum   = {1'b0, mn} + (CB + 1)'(prod >> phr_pkg::FRAC_BITS);
    third = (sum > {1'b0, mx}) ? mx : sum[CB-1:0];

    r_nxt = r1_r;
    g_nxt = g1_r;
    b_nxt = b1_r;
    if (in_range) begin
      if (mx == '0) begin
        r_nxt = '0;
        g_nxt = '0;
        b_nxt = '0;
      end else begin
        unique case (hue_cfg.sector)
          phr_pkg::SEC_R_MAX_G_UP: begin
            r_nxt = mx; g_nxt = third; b_nxt = mn;
          end
          phr_pkg::SEC_G_MAX_R_DOWN: begin
            g_nxt = mx; r_nxt = third; b_nxt = mn;
          end
          phr_pkg::SEC_G_MAX_B_UP: begin
            r_nxt = mn; g_nxt = mx; b_nxt = third;
          end
          phr_pkg::SEC_B_MAX_G_DOWN: begin
            r_nxt = mn; b_nxt = mx; g_nxt = third;
          end
          phr_pkg::SEC_B_MAX_R_UP: begin
            g_nxt = mn; b_nxt = mx; r_nxt = third;
          end
          default: begin
            g_nxt = mn; r_nxt = mx; b_nxt = third;
          end
        endcase
      end
    end
  end

  assign out_valid = vo_r;
  assign idx_out   = idxo_r;
  assign red_out   = ro_r;
  assign green_out = go_r;
  assign blue_out  = bo_r;

  a_two_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 vo_r)
    else $error("item lost between stages");
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> $past(v1_r))
    else $error("result without an item");

endmodule
